### hw/rtl/sat_pkg.sv
// Shared types and constants for the segment address translator.
// Used by the controller, the datapath, the top level and the checker.
package sat_pkg;

  localparam int TABLE_ENTRIES = 8192;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = 14;
  localparam int SLOT_W        = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int DESC_W        = 64;
  localparam int ADDR_W        = 32;
  localparam int SEL_W         = 16;
  localparam int LIMIT_W       = 20;

  localparam logic [1:0] MODE_XLATE  = 2'd0;
  localparam logic [1:0] MODE_WR_GDT = 2'd1;
  localparam logic [1:0] MODE_WR_LDT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GDT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LDT_COUNT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;    // store the request's descriptor
    logic rd_en;    // capture a translate request and read both tables
    logic eval;     // run the checks and load the result register
  } sat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_xlate;
  } sat_stat_t;

endpackage

### hw/rtl/sat_ctrl.sv
// Controller for the segment address translator: request handshake and sequencing.
// Depends on sat_pkg.
module sat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sat_pkg::sat_stat_t stat,
  output sat_pkg::sat_cmd_t  cmd
);
  import sat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign take      = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd.wr_en = take && !stat.is_xlate;
    cmd.rd_en = take && stat.is_xlate;
    cmd.eval  = (state_r == S_EVAL);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && stat.is_xlate) state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/sat_dp.sv
// Datapath for the segment address translator: descriptor tables, count
// registers, limit check and base add. Depends on sat_pkg.
module sat_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sat_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [1:0]                         in_mode,
  input  logic [sat_pkg::ADDR_W-1:0]         in_offset,
  input  logic [sat_pkg::SEL_W-1:0]          in_selector,
  input  logic [sat_pkg::SLOT_W-1:0]         in_entry_index,
  input  logic [sat_pkg::DESC_W-1:0]         in_entry_data,
  input  sat_pkg::sat_cmd_t                  cmd,
  output sat_pkg::sat_stat_t                 stat,
  output logic                               out_valid_res,
  output logic [sat_pkg::ADDR_W-1:0]         out_physical_address
);
  import sat_pkg::*;

  logic [DESC_W-1:0] gdt_mem [TABLE_ENTRIES];
  logic [DESC_W-1:0] ldt_mem [TABLE_ENTRIES];
  logic [DESC_W-1:0] gdt_rd_r, ldt_rd_r;

  logic [CNT_W-1:0]  gdt_cnt_r, ldt_cnt_r;
  logic [ADDR_W-1:0] offset_r;
  logic [SEL_W-1:0]  sel_r;
  logic              res_ok_r;
  logic [ADDR_W-1:0] res_addr_r;

  logic              slot_ok;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [CNT_W-1:0]  gdt_eff, ldt_eff, sel_idx;
  logic              use_ldt, idx_ok, lim_ok;
  logic [DESC_W-1:0] desc;
  logic [LIMIT_W-1:0] raw_lim;
  logic [ADDR_W-1:0] lim, base;

  assign stat.is_xlate = (in_mode == MODE_XLATE);

  assign slot_ok = ({1'b0, in_entry_index} < CNT_W'(TABLE_ENTRIES));
  assign wr_addr = in_entry_index[IDX_W-1:0];
  assign rd_addr = in_selector[IDX_W+2:3];

  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok && (in_mode == MODE_WR_GDT)) gdt_mem[wr_addr] <= in_entry_data;
    if (cmd.rd_en) gdt_rd_r <= gdt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok && (in_mode == MODE_WR_LDT)) ldt_mem[wr_addr] <= in_entry_data;
    if (cmd.rd_en) ldt_rd_r <= ldt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gdt_cnt_r <= '0;
      ldt_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GDT_COUNT: gdt_cnt_r <= cfg_wdata;
        REG_LDT_COUNT: ldt_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      offset_r <= in_offset;
      sel_r    <= in_selector;
    end
  end

  // Saturate counts at the table depth
  assign gdt_eff = (gdt_cnt_r > CNT_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES) : gdt_cnt_r;
  assign ldt_eff = (ldt_cnt_r > CNT_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES) : ldt_cnt_r;

  assign sel_idx = {1'b0, sel_r[15:3]};
  assign use_ldt = sel_r[2];
  assign idx_ok  = use_ldt ? (sel_idx < ldt_eff)
                           : ((sel_idx != '0) && (sel_idx < gdt_eff));
  assign desc    = use_ldt ? ldt_rd_r : gdt_rd_r;

  assign raw_lim = {desc[51:48], desc[15:0]};
  assign lim     = desc[55] ? {raw_lim, 12'hFFF} : {12'h000, raw_lim};
  // Expand-down segments are valid above the limit
  assign lim_ok  = desc[42] ? (offset_r > lim) : (offset_r <= lim);
  assign base    = {desc[63:56], desc[39:16]};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_ok_r   <= idx_ok && lim_ok;
      res_addr_r <= (idx_ok && lim_ok) ? (base + offset_r) : '0;
    end
  end

  assign out_valid_res        = res_ok_r;
  assign out_physical_address = res_addr_r;

endmodule

### hw/rtl/segment_address_translator_unit.sv
// Segment address translator: turns a 16-bit selector and 32-bit offset into
// a 32-bit linear address through a global and a local descriptor table of
// 8192 64-bit entries each. Write requests (modes 1 and 2) store a descriptor
// and finish in the cycle they are accepted; mode 3 is dropped. A translate
// request (mode 0) passes through the registered table read, then the limit
// check and base add into the result register, and is then held on out_valid
// until it is taken. The block takes one request at a time, so a translate
// occupies it until its result leaves, including any time the result waits
// on out_stall. Tables come up undefined and need no clearing after reset;
// entry counts reset to zero. Depends on sat_pkg, sat_ctrl and sat_dp.
module segment_address_translator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [sat_pkg::ADDR_W-1:0]    in_offset,
  input  logic [sat_pkg::SEL_W-1:0]     in_selector,
  input  logic [sat_pkg::SLOT_W-1:0]    in_entry_index,
  input  logic [sat_pkg::DESC_W-1:0]    in_entry_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_valid_res,
  output logic [sat_pkg::ADDR_W-1:0]    out_physical_address
);
  import sat_pkg::*;

  sat_cmd_t  cmd;
  sat_stat_t stat;

  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sat_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_mode),
    .in_offset            (in_offset),
    .in_selector          (in_selector),
    .in_entry_index       (in_entry_index),
    .in_entry_data        (in_entry_data),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid_res        (out_valid_res),
    .out_physical_address (out_physical_address)
  );

endmodule

### hw/rtl/sat_checker.sv
// Port-level checks for the segment address translator, bound to the top level.
// Depends on sat_pkg.
module sat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    in_mode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_valid_res,
  input logic [sat_pkg::ADDR_W-1:0]    out_physical_address
);
  import sat_pkg::*;

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_valid_res)
      && $stable(out_physical_address))
    else $error("stalled result changed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_physical_address == '0)
    else $error("faulted translate carries a nonzero address");

  a_xlate_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_mode == MODE_XLATE |=> !out_valid ##1 out_valid)
    else $error("translate result not on time");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_mode != MODE_XLATE |=> !out_valid)
    else $error("write request produced a result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

endmodule

bind segment_address_translator_unit sat_checker u_sat_checker (.*);
